### rtl/core/lfpd_pkg.sv
// shared types and constants of the line follower steering block
// no dependencies; every other file of the block refers to this package
`default_nettype none

package lfpd_pkg;

    // frame geometry and field widths
    localparam int NUM_SENSORS = 6;
    localparam int SAMPLE_W    = 8;
    localparam int ERR_W       = 5;
    localparam int SUM_W       = 6;
    localparam int CNT_W       = 3;
    localparam int GAIN_W      = 4;
    localparam int DUTY_W      = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    // restoring divider: one quotient bit per step over the error magnitude
    localparam int DIV_MAG_W = ERR_W;
    localparam int DIV_REM_W = CNT_W;
    localparam int DIV_STEPS = DIV_MAG_W;

    // sensor weights, leftmost first
    localparam logic signed [ERR_W-1:0] SENSOR_WEIGHT [NUM_SENSORS] =
        '{-5'sd10, -5'sd7, -5'sd5, 5'sd5, 5'sd7, 5'sd10};

    // error used when the line is lost
    localparam logic signed [ERR_W-1:0] LOST_FAR_POS = 5'sd12;
    localparam logic signed [ERR_W-1:0] LOST_FAR_NEG = -5'sd12;
    localparam logic signed [ERR_W-1:0] LOST_EDGE_POS = 5'sd7;
    localparam logic signed [ERR_W-1:0] LOST_EDGE_NEG = -5'sd7;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_BASE_DUTY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BASE_DUTY  = 3'd4;

    // reset values of the registers
    localparam logic [SAMPLE_W-1:0] RST_DETECT_THRESHOLD = 8'd150;
    localparam logic [GAIN_W-1:0]   RST_PROP_GAIN        = 4'd2;
    localparam logic [GAIN_W-1:0]   RST_DERIV_GAIN       = 4'd1;
    localparam logic [DUTY_W-1:0]   RST_LEFT_BASE_DUTY   = 10'd40;
    localparam logic [DUTY_W-1:0]   RST_RIGHT_BASE_DUTY  = 10'd33;

    // sequencer of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_ERROR,
        ST_DIVIDE,
        ST_PD,
        ST_CLAMP
    } lfpd_state_t;

endpackage

`default_nettype wire

### rtl/core/lfpd_lane.sv
// one sensor lane: threshold compare and weighted contribution
// depends on lfpd_pkg
`default_nettype none

module lfpd_lane (
    input  wire logic                                clk,
    input  wire logic                                load,
    input  wire logic [lfpd_pkg::SAMPLE_W-1:0]       sample,
    input  wire logic [lfpd_pkg::SAMPLE_W-1:0]       threshold,
    input  wire logic signed [lfpd_pkg::ERR_W-1:0]   weight,
    output logic                                     hit,
    output logic signed [lfpd_pkg::ERR_W-1:0]        contrib
);

    logic                               hit_reg;
    logic                               hit_next;
    logic signed [lfpd_pkg::ERR_W-1:0]  contrib_reg;
    logic signed [lfpd_pkg::ERR_W-1:0]  contrib_next;

    // sample strictly above threshold sees the line
    always_comb
    begin
        hit_next     = (sample > threshold);
        contrib_next = hit_next ? weight : '0;
    end

    // capture on the accepted beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_reg     <= hit_next;
            contrib_reg <= contrib_next;
        end
    end

    assign hit     = hit_reg;
    assign contrib = contrib_reg;

endmodule

`default_nettype wire

### rtl/core/lfpd_merge.sv
// merge stage: sums the lane contributions and counts the lanes on the line
// depends on lfpd_pkg
`default_nettype none

module lfpd_merge (
    input  wire logic                                    clk,
    input  wire logic                                    load,
    input  wire logic [lfpd_pkg::NUM_SENSORS-1:0]        hits,
    input  wire logic signed [lfpd_pkg::ERR_W-1:0]       contribs [lfpd_pkg::NUM_SENSORS],
    output logic signed [lfpd_pkg::SUM_W-1:0]            sum,
    output logic [lfpd_pkg::CNT_W-1:0]                   count
);

    logic signed [lfpd_pkg::SUM_W-1:0] sum_reg;
    logic signed [lfpd_pkg::SUM_W-1:0] sum_next;
    logic [lfpd_pkg::CNT_W-1:0]        count_reg;
    logic [lfpd_pkg::CNT_W-1:0]        count_next;

    // adder chain over the six narrow lane results
    always_comb
    begin
        sum_next   = '0;
        count_next = '0;
        for (int i = 0; i < lfpd_pkg::NUM_SENSORS; i++)
        begin
            sum_next   = sum_next + lfpd_pkg::SUM_W'(contribs[i]);
            count_next = count_next + lfpd_pkg::CNT_W'(hits[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assign sum   = sum_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

### rtl/core/lfpd_div.sv
// restoring divider for the centroid: signed sum over hit count,
// quotient truncated toward zero; depends on lfpd_pkg
`default_nettype none

module lfpd_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [lfpd_pkg::SUM_W-1:0]     dividend,
    input  wire logic [lfpd_pkg::CNT_W-1:0]            divisor,
    output logic                                       done,
    output logic signed [lfpd_pkg::ERR_W-1:0]          quotient
);

    localparam logic [lfpd_pkg::CNT_W-1:0] LAST_STEP =
        lfpd_pkg::CNT_W'(lfpd_pkg::DIV_STEPS - 1);

    logic                               busy_reg;
    logic                               busy_next;
    logic                               done_reg;
    logic                               done_next;
    logic [lfpd_pkg::CNT_W-1:0]         cnt_reg;
    logic [lfpd_pkg::CNT_W-1:0]         cnt_next;
    logic [lfpd_pkg::DIV_MAG_W-1:0]     mag_reg;
    logic [lfpd_pkg::DIV_MAG_W-1:0]     mag_next;
    logic [lfpd_pkg::DIV_REM_W-1:0]     rem_reg;
    logic [lfpd_pkg::DIV_REM_W-1:0]     rem_next;
    logic [lfpd_pkg::CNT_W-1:0]         dsor_reg;
    logic [lfpd_pkg::CNT_W-1:0]         dsor_next;
    logic                               neg_reg;
    logic                               neg_next;
    logic [lfpd_pkg::DIV_REM_W:0]       trial;
    logic                               qbit;
    logic signed [lfpd_pkg::SUM_W-1:0]  abs_dividend;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        dsor_next    = dsor_reg;
        neg_next     = neg_reg;
        abs_dividend = dividend[lfpd_pkg::SUM_W-1] ? -dividend : dividend;
        trial        = {rem_reg, mag_reg[lfpd_pkg::DIV_MAG_W-1]};
        qbit         = (trial >= {1'b0, dsor_reg});

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mag_next  = abs_dividend[lfpd_pkg::DIV_MAG_W-1:0];
            rem_next  = '0;
            dsor_next = divisor;
            neg_next  = dividend[lfpd_pkg::SUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? lfpd_pkg::DIV_REM_W'(trial - {1'b0, dsor_reg})
                            : trial[lfpd_pkg::DIV_REM_W-1:0];
            mag_next = {mag_reg[lfpd_pkg::DIV_MAG_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        dsor_reg <= dsor_next;
        neg_reg  <= neg_next;
    end

    // restore the sign of the magnitude quotient
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

`default_nettype wire

### rtl/core/line_follower_pd_steering_top.sv
// Line follower steering block: six sensor lanes with a merge stage, a serial
// divider for the centroid and a PD correction of the two motor duties.
// One frame is taken at a time. A frame in which some sensor sees the line
// goes through the merge, the error step, the five restoring steps of the
// divider, the PD step and the clamp; a frame with the line lost skips the
// divider. The next frame is taken as soon as the result is in the output
// register, even while that result waits to be taken.
// Depends on lfpd_pkg, lfpd_lane, lfpd_merge and lfpd_div.
`default_nettype none

module line_follower_pd_steering_top #(
    parameter int unsigned DUTY_MAX = 1023
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   cfg_we,
    input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [lfpd_pkg::SAMPLE_W-1:0]          sample_one,
    input  wire logic [lfpd_pkg::SAMPLE_W-1:0]          sample_two,
    input  wire logic [lfpd_pkg::SAMPLE_W-1:0]          sample_three,
    input  wire logic [lfpd_pkg::SAMPLE_W-1:0]          sample_four,
    input  wire logic [lfpd_pkg::SAMPLE_W-1:0]          sample_five,
    input  wire logic [lfpd_pkg::SAMPLE_W-1:0]          sample_six,

    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [lfpd_pkg::DUTY_W-1:0]                 left_duty,
    output logic [lfpd_pkg::DUTY_W-1:0]                 right_duty,
    output logic signed [lfpd_pkg::ERR_W-1:0]           position_error,
    output logic                                        line_lost
);

    localparam int DUTY_CALC_W = 13;
    localparam int CMP_W       = 18;
    localparam logic signed [CMP_W-1:0] DUTY_MAX_S = CMP_W'(DUTY_MAX);
    localparam logic [lfpd_pkg::DUTY_W-1:0] DUTY_MAX_TRUNC =
        lfpd_pkg::DUTY_W'(DUTY_MAX);

    // configuration registers
    logic [lfpd_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [lfpd_pkg::GAIN_W-1:0]   prop_gain_reg;
    logic [lfpd_pkg::GAIN_W-1:0]   deriv_gain_reg;
    logic [lfpd_pkg::DUTY_W-1:0]   left_base_reg;
    logic [lfpd_pkg::DUTY_W-1:0]   right_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= lfpd_pkg::RST_DETECT_THRESHOLD;
            prop_gain_reg  <= lfpd_pkg::RST_PROP_GAIN;
            deriv_gain_reg <= lfpd_pkg::RST_DERIV_GAIN;
            left_base_reg  <= lfpd_pkg::RST_LEFT_BASE_DUTY;
            right_base_reg <= lfpd_pkg::RST_RIGHT_BASE_DUTY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lfpd_pkg::REG_DETECT_THRESHOLD:
                    threshold_reg  <= cfg_data[lfpd_pkg::SAMPLE_W-1:0];
                lfpd_pkg::REG_PROP_GAIN:
                    prop_gain_reg  <= cfg_data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::REG_DERIV_GAIN:
                    deriv_gain_reg <= cfg_data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::REG_LEFT_BASE_DUTY:
                    left_base_reg  <= cfg_data[lfpd_pkg::DUTY_W-1:0];
                lfpd_pkg::REG_RIGHT_BASE_DUTY:
                    right_base_reg <= cfg_data[lfpd_pkg::DUTY_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // sequencer and handshake
    lfpd_pkg::lfpd_state_t state_reg;
    lfpd_pkg::lfpd_state_t state_next;

    logic in_accept;
    logic out_free;
    logic merge_load;
    logic div_start;
    logic div_done;

    assign in_stall  = (state_reg != lfpd_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid || !out_stall;

    // sensor lanes
    logic [lfpd_pkg::SAMPLE_W-1:0]      samples  [lfpd_pkg::NUM_SENSORS];
    logic [lfpd_pkg::NUM_SENSORS-1:0]   hits;
    logic signed [lfpd_pkg::ERR_W-1:0]  contribs [lfpd_pkg::NUM_SENSORS];

    assign samples[0] = sample_one;
    assign samples[1] = sample_two;
    assign samples[2] = sample_three;
    assign samples[3] = sample_four;
    assign samples[4] = sample_five;
    assign samples[5] = sample_six;

    for (genvar g = 0; g < lfpd_pkg::NUM_SENSORS; g++)
    begin : g_lane
        lfpd_lane u_lane (
            .clk       (clk),
            .load      (in_accept),
            .sample    (samples[g]),
            .threshold (threshold_reg),
            .weight    (lfpd_pkg::SENSOR_WEIGHT[g]),
            .hit       (hits[g]),
            .contrib   (contribs[g])
        );
    end

    // merge of the lane results
    logic signed [lfpd_pkg::SUM_W-1:0] sum;
    logic [lfpd_pkg::CNT_W-1:0]        count;

    lfpd_merge u_merge (
        .clk      (clk),
        .load     (merge_load),
        .hits     (hits),
        .contribs (contribs),
        .sum      (sum),
        .count    (count)
    );

    // centroid division
    logic signed [lfpd_pkg::ERR_W-1:0] quotient;

    lfpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum),
        .divisor  (count),
        .done     (div_done),
        .quotient (quotient)
    );

    // error, PD products and output registers
    logic signed [lfpd_pkg::ERR_W-1:0]   err_reg;
    logic signed [lfpd_pkg::ERR_W-1:0]   err_next;
    logic                                lost_reg;
    logic                                lost_next;
    logic signed [lfpd_pkg::ERR_W-1:0]   last_error_reg;
    logic signed [lfpd_pkg::ERR_W-1:0]   last_error_next;
    logic signed [9:0]                   p_term_reg;
    logic signed [9:0]                   p_term_next;
    logic signed [10:0]                  d_term_reg;
    logic signed [10:0]                  d_term_next;
    logic signed [lfpd_pkg::ERR_W:0]     err_diff;
    logic signed [11:0]                  corr;
    logic signed [DUTY_CALC_W-1:0]       left_raw;
    logic signed [DUTY_CALC_W-1:0]       right_raw;
    logic [lfpd_pkg::DUTY_W-1:0]         left_clamped;
    logic [lfpd_pkg::DUTY_W-1:0]         right_clamped;
    logic                                out_load;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [lfpd_pkg::DUTY_W-1:0]         left_duty_reg;
    logic [lfpd_pkg::DUTY_W-1:0]         right_duty_reg;
    logic signed [lfpd_pkg::ERR_W-1:0]   pos_err_reg;
    logic                                line_lost_reg;

    // duty clamp to 0..DUTY_MAX, then reduced to the field width
    function automatic logic [lfpd_pkg::DUTY_W-1:0] clamp_duty(
        input logic signed [DUTY_CALC_W-1:0] v
    );
        logic signed [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        if (wide < 0)
            clamp_duty = '0;
        else if (wide > DUTY_MAX_S)
            clamp_duty = DUTY_MAX_TRUNC;
        else
            clamp_duty = v[lfpd_pkg::DUTY_W-1:0];
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        merge_load      = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        err_next        = err_reg;
        lost_next       = lost_reg;
        last_error_next = last_error_reg;

        err_diff    = (lfpd_pkg::ERR_W+1)'(err_reg) - (lfpd_pkg::ERR_W+1)'(last_error_reg);
        p_term_next = 10'($signed({1'b0, prop_gain_reg}) * err_reg);
        d_term_next = 11'($signed({1'b0, deriv_gain_reg}) * err_diff);

        corr      = 12'(p_term_reg) + 12'(d_term_reg);
        left_raw  = $signed({3'b000, left_base_reg}) - DUTY_CALC_W'(corr);
        right_raw = $signed({3'b000, right_base_reg}) + DUTY_CALC_W'(corr);
        left_clamped  = clamp_duty(left_raw);
        right_clamped = clamp_duty(right_raw);

        case (state_reg)
            lfpd_pkg::ST_IDLE:
            begin
                if (in_accept)
                    state_next = lfpd_pkg::ST_MERGE;
            end
            lfpd_pkg::ST_MERGE:
            begin
                merge_load = 1'b1;
                state_next = lfpd_pkg::ST_ERROR;
            end
            lfpd_pkg::ST_ERROR:
            begin
                // no sensor on the line: hold the far side where it was last seen past the edge, else zero error
                if (count == '0)
                begin
                    lost_next = 1'b1;
                    if (last_error_reg < lfpd_pkg::LOST_EDGE_NEG)
                        err_next = lfpd_pkg::LOST_FAR_NEG;
                    else if (last_error_reg > lfpd_pkg::LOST_EDGE_POS)
                        err_next = lfpd_pkg::LOST_FAR_POS;
                    else
                        err_next = '0;
                    state_next = lfpd_pkg::ST_PD;
                end
                else
                begin
                    lost_next  = 1'b0;
                    div_start  = 1'b1;
                    state_next = lfpd_pkg::ST_DIVIDE;
                end
            end
            lfpd_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    err_next   = quotient;
                    state_next = lfpd_pkg::ST_PD;
                end
            end
            lfpd_pkg::ST_PD:
            begin
                state_next = lfpd_pkg::ST_CLAMP;
            end
            lfpd_pkg::ST_CLAMP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    last_error_next = err_reg;
                    state_next      = lfpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfpd_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lfpd_pkg::ST_IDLE;
            last_error_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_error_reg <= last_error_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        err_reg    <= err_next;
        lost_reg   <= lost_next;
        if (state_reg == lfpd_pkg::ST_PD)
        begin
            p_term_reg <= p_term_next;
            d_term_reg <= d_term_next;
        end
        if (out_load)
        begin
            left_duty_reg  <= left_clamped;
            right_duty_reg <= right_clamped;
            pos_err_reg    <= err_reg;
            line_lost_reg  <= lost_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_duty      = left_duty_reg;
    assign right_duty     = right_duty_reg;
    assign position_error = pos_err_reg;
    assign line_lost      = line_lost_reg;

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench for line_follower_pd_steering_top: sensor frames, checked result by result
// against an in-bench steering predictor; depends on lfpd_pkg and the block's rtl

module testbench;

    localparam int DUTY_MAX      = 1023;
    localparam int SAMPLE_MAX    = 2**lfpd_pkg::SAMPLE_W - 1;
    localparam int FRAME_LATENCY = 11;
    localparam int LOST_EDGE     = 7;
    localparam int LOST_FAR      = 12;
    localparam int BURST_MAX     = 14;
    localparam int HOLD_CYCLES   = 120;
    localparam int HOLD_PHASE    = 3;
    localparam int QUIET_LIMIT   = 1000;
    localparam int PHASES        = 8;
    localparam int PHASE_FRAMES  = 54;

    typedef logic [lfpd_pkg::NUM_SENSORS-1:0][lfpd_pkg::SAMPLE_W-1:0] frame_t;

    typedef struct packed {
        logic [lfpd_pkg::DUTY_W-1:0]       left;
        logic [lfpd_pkg::DUTY_W-1:0]       right;
        logic signed [lfpd_pkg::ERR_W-1:0] err;
        logic                              lost;
    } steer_t;

    // dut ports
    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [lfpd_pkg::SAMPLE_W-1:0]     sample_one = '0;
    logic [lfpd_pkg::SAMPLE_W-1:0]     sample_two = '0;
    logic [lfpd_pkg::SAMPLE_W-1:0]     sample_three = '0;
    logic [lfpd_pkg::SAMPLE_W-1:0]     sample_four = '0;
    logic [lfpd_pkg::SAMPLE_W-1:0]     sample_five = '0;
    logic [lfpd_pkg::SAMPLE_W-1:0]     sample_six = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [lfpd_pkg::DUTY_W-1:0]       left_duty;
    logic [lfpd_pkg::DUTY_W-1:0]       right_duty;
    logic signed [lfpd_pkg::ERR_W-1:0] position_error;
    logic                              line_lost;

    // predictor copy of the registers and the error history
    int thr_cfg        = lfpd_pkg::RST_DETECT_THRESHOLD;
    int kp_cfg         = lfpd_pkg::RST_PROP_GAIN;
    int kd_cfg         = lfpd_pkg::RST_DERIV_GAIN;
    int left_base_cfg  = lfpd_pkg::RST_LEFT_BASE_DUTY;
    int right_base_cfg = lfpd_pkg::RST_RIGHT_BASE_DUTY;
    int last_err       = 0;

    int sensor_weight [lfpd_pkg::NUM_SENSORS] = '{-10, -7, -5, 5, 7, 10};

    // masks that put the line near one edge, so a following loss latches far or stays zero
    bit [lfpd_pkg::NUM_SENSORS-1:0] edge_masks [6] =
        '{6'b000001, 6'b000011, 6'b000010, 6'b100000, 6'b110000, 6'b010000};

    // directed walk and the register plan of the random phases
    bit [lfpd_pkg::NUM_SENSORS-1:0] walk_masks [15] = '{
        6'b000000, 6'b000000, 6'b000001, 6'b000000, 6'b000000,
        6'b000010, 6'b000000, 6'b010000, 6'b000000, 6'b000011,
        6'b000000, 6'b110000, 6'b000000, 6'b000111, 6'b111111};
    int  thr_plan  [PHASES] = '{0, 255, 127, 10, 240, 0, 0, 150};
    int  kp_plan   [PHASES] = '{15, 0, 15, 7, 0, 0, 0, 2};
    int  kd_plan   [PHASES] = '{15, 0, 0, 15, 9, 0, 0, 1};
    int  lb_plan   [PHASES] = '{0, 1023, 1023, 0, 512, 0, 0, 40};
    int  rb_plan   [PHASES] = '{1023, 0, 0, 1023, 512, 0, 0, 33};
    int  idle_plan [PHASES] = '{20, 35, 0, 15, 50, 25, 30, 0};
    bit  rand_plan [PHASES] = '{0, 0, 0, 0, 0, 1, 1, 0};

    frame_t pending_frames [$];
    steer_t expected_steer [$];
    frame_t drive_frame;
    steer_t want;

    int idle_pct       = 0;
    bit hold_req       = 1'b0;
    int send_gap       = 0;
    int stall_burst    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;
    int frames_checked = 0;
    int lost_frames    = 0;

    line_follower_pd_steering_top #(
        .DUTY_MAX(DUTY_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_one(sample_one),
        .sample_two(sample_two),
        .sample_three(sample_three),
        .sample_four(sample_four),
        .sample_five(sample_five),
        .sample_six(sample_six),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .left_duty(left_duty),
        .right_duty(right_duty),
        .position_error(position_error),
        .line_lost(line_lost)
    );

    always #1 clk = ~clk;

    // duty saturation to 0..DUTY_MAX
    function automatic logic [lfpd_pkg::DUTY_W-1:0] clamp_duty(int v);
        if (v < 0)
            v = 0;
        if (v > DUTY_MAX)
            v = DUTY_MAX;
        return lfpd_pkg::DUTY_W'(v);
    endfunction

    // centroid error, lost-line latch and pd correction for one frame
    function automatic steer_t predict_steering(frame_t f);
        int     sum;
        int     hits;
        int     err;
        int     corr;
        steer_t res;
        sum  = 0;
        hits = 0;
        for (int n = 0; n < lfpd_pkg::NUM_SENSORS; n++)
        begin
            if (int'(f[n]) > thr_cfg)
            begin
                sum  += sensor_weight[n];
                hits += 1;
            end
        end
        if (hits != 0)
            err = sum / hits;
        else if (last_err < -LOST_EDGE)
            err = -LOST_FAR;
        else if (last_err > LOST_EDGE)
            err = LOST_FAR;
        else
            err = 0;
        corr     = kp_cfg * err + kd_cfg * (err - last_err);
        last_err = err;
        res.left  = clamp_duty(left_base_cfg - corr);
        res.right = clamp_duty(right_base_cfg + corr);
        res.err   = lfpd_pkg::ERR_W'(err);
        res.lost  = (hits == 0);
        return res;
    endfunction

    // sample value on either side of the threshold, biased to the boundary
    function automatic logic [lfpd_pkg::SAMPLE_W-1:0] pick_sample(bit seen);
        if (seen && thr_cfg < SAMPLE_MAX)
        begin
            case ($urandom_range(0, 3))
                0:       return lfpd_pkg::SAMPLE_W'(thr_cfg + 1);
                1:       return lfpd_pkg::SAMPLE_W'(SAMPLE_MAX);
                default: return lfpd_pkg::SAMPLE_W'($urandom_range(thr_cfg + 1, SAMPLE_MAX));
            endcase
        end
        case ($urandom_range(0, 3))
            0:       return lfpd_pkg::SAMPLE_W'(thr_cfg);
            1:       return '0;
            default: return lfpd_pkg::SAMPLE_W'($urandom_range(0, thr_cfg));
        endcase
    endfunction

    function automatic frame_t make_frame(bit [lfpd_pkg::NUM_SENSORS-1:0] on_mask);
        frame_t f;
        for (int n = 0; n < lfpd_pkg::NUM_SENSORS; n++)
            f[n] = pick_sample(on_mask[n]);
        return f;
    endfunction

    // register write with junk above the register width; predictor copy follows
    task automatic write_reg(input logic [lfpd_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        logic [lfpd_pkg::CFG_DATA_W-1:0] data;
        data = lfpd_pkg::CFG_DATA_W'($urandom);
        case (idx)
            lfpd_pkg::REG_DETECT_THRESHOLD:
            begin
                data[lfpd_pkg::SAMPLE_W-1:0] = lfpd_pkg::SAMPLE_W'(value);
                thr_cfg = data[lfpd_pkg::SAMPLE_W-1:0];
            end
            lfpd_pkg::REG_PROP_GAIN:
            begin
                data[lfpd_pkg::GAIN_W-1:0] = lfpd_pkg::GAIN_W'(value);
                kp_cfg = data[lfpd_pkg::GAIN_W-1:0];
            end
            lfpd_pkg::REG_DERIV_GAIN:
            begin
                data[lfpd_pkg::GAIN_W-1:0] = lfpd_pkg::GAIN_W'(value);
                kd_cfg = data[lfpd_pkg::GAIN_W-1:0];
            end
            lfpd_pkg::REG_LEFT_BASE_DUTY:
            begin
                data = lfpd_pkg::DUTY_W'(value);
                left_base_cfg = data;
            end
            lfpd_pkg::REG_RIGHT_BASE_DUTY:
            begin
                data = lfpd_pkg::DUTY_W'(value);
                right_base_cfg = data;
            end
            default:
            begin
                // index past the register list: the block drops it
            end
        endcase
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly edge-then-lost runs and threshold-aware frames, some raw noise
    task automatic queue_random_frames(input int count);
        int     queued;
        int     k;
        frame_t raw;
        queued = 0;
        while (queued < count)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    pending_frames.push_back(make_frame(edge_masks[$urandom_range(0, 5)]));
                    k = $urandom_range(1, 3);
                    repeat (k) pending_frames.push_back(make_frame('0));
                    queued += k + 1;
                end
                2:
                begin
                    pending_frames.push_back(make_frame('0));
                    queued++;
                end
                3, 4:
                begin
                    raw = {$urandom, 16'($urandom)};
                    pending_frames.push_back(raw);
                    queued++;
                end
                default:
                begin
                    pending_frames.push_back(make_frame(lfpd_pkg::NUM_SENSORS'($urandom)));
                    queued++;
                end
            endcase
        end
    endtask

    // wait for every frame to be sent and answered, then let the pipe settle;
    // checked between edges so the driver's last beat is already visible
    task automatic drain();
        @(negedge clk);
        while (pending_frames.size() > 0 || in_valid || expected_steer.size() > 0)
            @(negedge clk);
        repeat (FRAME_LATENCY + 1) @(posedge clk);
    endtask

    // input driver: one beat per pending frame, idle bursts between
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_steer.push_back(predict_steering({sample_six, sample_five,
                    sample_four, sample_three, sample_two, sample_one}));
            if (!in_valid || !in_stall)
            begin
                if (send_gap == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                    send_gap = $urandom_range(1, BURST_MAX);
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_frames.size() > 0)
                begin
                    drive_frame = pending_frames.pop_front();
                    sample_one   <= drive_frame[0];
                    sample_two   <= drive_frame[1];
                    sample_three <= drive_frame[2];
                    sample_four  <= drive_frame[3];
                    sample_five  <= drive_frame[4];
                    sample_six   <= drive_frame[5];
                    in_valid     <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_burst = 0;
            hold_left   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_steer.size() == 0)
                begin
                    $error("result beat with no frame outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_steer.pop_front();
                    frames_checked++;
                    if (want.lost)
                        lost_frames++;
                    if (left_duty !== want.left)
                    begin
                        $error("left_duty expected %0d got %0d", want.left, left_duty);
                        mismatch_count++;
                    end
                    if (right_duty !== want.right)
                    begin
                        $error("right_duty expected %0d got %0d", want.right, right_duty);
                        mismatch_count++;
                    end
                    if (position_error !== want.err)
                    begin
                        $error("position_error expected %0d got %0d",
                               $signed(want.err), $signed(position_error));
                        mismatch_count++;
                    end
                    if (line_lost !== want.lost)
                    begin
                        $error("line_lost expected %0d got %0d", want.lost, line_lost);
                        mismatch_count++;
                    end
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (stall_burst == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                    stall_burst = $urandom_range(1, BURST_MAX);
                if (stall_burst > 0)
                begin
                    stall_burst--;
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        int p;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames on the reset settings: threshold boundary, each weight,
        // far-left and far-right loss latching, loss right at the edge, truncation
        @(negedge clk);
        idle_pct = 10;
        pending_frames.push_back({lfpd_pkg::NUM_SENSORS{lfpd_pkg::SAMPLE_W'(thr_cfg)}});
        pending_frames.push_back({lfpd_pkg::NUM_SENSORS{lfpd_pkg::SAMPLE_W'(thr_cfg + 1)}});
        pending_frames.push_back({lfpd_pkg::NUM_SENSORS{lfpd_pkg::SAMPLE_W'(SAMPLE_MAX)}});
        pending_frames.push_back('0);
        for (int n = 0; n < lfpd_pkg::NUM_SENSORS; n++)
            pending_frames.push_back(make_frame(lfpd_pkg::NUM_SENSORS'(1) << n));
        foreach (walk_masks[i])
            pending_frames.push_back(make_frame(walk_masks[i]));
        drain();

        // random frames under a series of register settings
        for (p = 0; p < PHASES; p++)
        begin
            if (rand_plan[p])
            begin
                thr_plan[p] = $urandom_range(0, SAMPLE_MAX);
                kp_plan[p]  = $urandom_range(0, 2**lfpd_pkg::GAIN_W - 1);
                kd_plan[p]  = $urandom_range(0, 2**lfpd_pkg::GAIN_W - 1);
                lb_plan[p]  = $urandom_range(0, 2**lfpd_pkg::DUTY_W - 1);
                rb_plan[p]  = $urandom_range(0, 2**lfpd_pkg::DUTY_W - 1);
            end
            write_reg(lfpd_pkg::REG_DETECT_THRESHOLD, thr_plan[p]);
            write_reg(lfpd_pkg::REG_PROP_GAIN, kp_plan[p]);
            write_reg(lfpd_pkg::REG_DERIV_GAIN, kd_plan[p]);
            write_reg(lfpd_pkg::REG_LEFT_BASE_DUTY, lb_plan[p]);
            write_reg(lfpd_pkg::REG_RIGHT_BASE_DUTY, rb_plan[p]);
            write_reg(lfpd_pkg::CFG_IDX_W'(lfpd_pkg::REG_RIGHT_BASE_DUTY + 1
                                           + $urandom_range(0, 2)), $urandom);
            @(negedge clk);
            idle_pct = idle_plan[p];
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            queue_random_frames(PHASE_FRAMES);
            drain();
        end

        $display("%0d frames checked, %0d with the line lost, over %0d register settings",
                 frames_checked, lost_frames, PHASES + 1);
        if (mismatch_count == 0 && expected_steer.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/core/lfpd_pkg.sv
rtl/core/lfpd_lane.sv
rtl/core/lfpd_merge.sv
rtl/core/lfpd_div.sv
rtl/core/line_follower_pd_steering_top.sv
dv/testbench.sv
